### rtl/llcp_pkg.sv
// Package for the closest-points-between-two-lines core.
// Holds request/result structs, internal widths, pipeline latencies and side-data types.
// No dependencies.
`default_nettype none
package llcp_pkg;

  localparam int COORD_W       = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MUL_CHUNK     = 32;

  // internal exact widths
  localparam int PW  = COORD_W + 1;       // point differences
  localparam int DW  = 2 * PW + 2;        // dot products
  localparam int MW  = 2 * DW + 1;        // denom, numer
  localparam int DBW = DW + MW;           // db
  localparam int NBW = DBW + 1;           // nb
  localparam int PAW = MW + PW + 1;       // Pa numerators
  localparam int PBW = NBW + PW + 1;      // Pb numerators

  localparam int NC_PW  = (PW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NC_DW  = (DW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NC_MW  = (MW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NC_CW  = (COORD_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NC_DBW = (DBW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NC_NBW = (NBW + MUL_CHUNK - 1) / MUL_CHUNK;

  localparam int ST_C0 = NC_DW * NC_MW;
  localparam int ST_C1 = NC_CW * NC_MW;
  localparam int ST_C2 = NC_MW * NC_PW;
  localparam int ST_C01 = (ST_C0 > ST_C1) ? ST_C0 : ST_C1;
  localparam int ST_D0 = NC_CW * NC_DBW;
  localparam int ST_D1 = NC_NBW * NC_PW;

  localparam int LAT_A = NC_PW * NC_PW + 2;
  localparam int LAT_B = NC_DW * NC_DW + 2;
  localparam int LAT_C = ((ST_C01 > ST_C2) ? ST_C01 : ST_C2) + 2;
  localparam int LAT_D = ((ST_D0 > ST_D1) ? ST_D0 : ST_D1) + 2;
  localparam int LAT_Q = COORD_W + 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [PW-1:0]  diff_t;
  typedef logic [DW-1:0]  dot_t;
  typedef logic [MW-1:0]  mid_t;
  typedef logic [DBW-1:0] db_t;
  typedef logic [NBW-1:0] nb_t;
  typedef logic [PAW-1:0] pa_t;
  typedef logic [PBW-1:0] pb_t;

  typedef struct packed {
    coord_t line_a_start_x;
    coord_t line_a_start_y;
    coord_t line_a_start_z;
    coord_t line_a_end_x;
    coord_t line_a_end_y;
    coord_t line_a_end_z;
    coord_t line_b_start_x;
    coord_t line_b_start_y;
    coord_t line_b_start_z;
    coord_t line_b_end_x;
    coord_t line_b_end_y;
    coord_t line_b_end_z;
  } line_req_t;

  typedef struct packed {
    logic   valid_res;
    coord_t param_a;
    coord_t param_b;
    coord_t near_a_x;
    coord_t near_a_y;
    coord_t near_a_z;
    coord_t near_b_x;
    coord_t near_b_y;
    coord_t near_b_z;
  } line_rsp_t;

  typedef struct packed {
    logic              deg;
    coord_t [2:0]      a1;
    coord_t [2:0]      b1;
    diff_t  [2:0]      p21;
    diff_t  [2:0]      p43;
  } side_a_t;

  typedef struct packed {
    logic              deg;
    dot_t              d1343;
    dot_t              d4321;
    dot_t              d4343;
    coord_t [2:0]      a1;
    coord_t [2:0]      b1;
    diff_t  [2:0]      p21;
    diff_t  [2:0]      p43;
  } side_b_t;

  typedef struct packed {
    logic              ok;
    mid_t              numer;
    mid_t              denom;
    coord_t [2:0]      b1;
    diff_t  [2:0]      p43;
  } side_c_t;

  typedef struct packed {
    logic              ok;
    mid_t              numer;
    mid_t              denom;
    db_t               db;
    nb_t               nb;
    pa_t    [2:0]      pa;
  } side_d_t;

  typedef struct packed {
    logic              ok;
    mid_t              numer;
    mid_t              denom;
    db_t               db;
    nb_t               nb;
    pa_t    [2:0]      pa;
    pb_t    [2:0]      pb;
  } side_e_t;

endpackage
`default_nettype wire

### rtl/llcp_delay.sv
// Valid-tagged delay line that keeps side data aligned with the arithmetic units.
// Depends on nothing beyond its type parameter.
`default_nettype none
module llcp_delay #(
  parameter type T     = logic,
  parameter int  DEPTH = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic in_vld,
  input  T     in_data,
  output logic out_vld,
  output T     out_data
);

  logic [DEPTH-1:0] vld;
  T                 data [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld[0] <= in_vld;
      for (int i = 1; i < DEPTH; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    data[0] <= in_data;
    for (int i = 1; i < DEPTH; i++) begin
      data[i] <= data[i-1];
    end
  end

  assign out_vld  = vld[DEPTH-1];
  assign out_data = data[DEPTH-1];

endmodule
`default_nettype wire

### rtl/llcp_mul.sv
// Pipelined signed multiplier: one chunk-by-chunk partial product per stage.
// Depends on llcp_pkg (MUL_CHUNK). LAT must exceed the partial-product count by two.
`default_nettype none
module llcp_mul #(
  parameter int WA  = 33,
  parameter int WB  = 33,
  parameter int LAT = 6
) (
  input  logic             clk,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);
  import llcp_pkg::*;

  localparam int G     = MUL_CHUNK;
  localparam int NA    = (WA + G - 1) / G;
  localparam int NB    = (WB + G - 1) / G;
  localparam int STEPS = NA * NB;
  localparam int AW    = NA * G;
  localparam int BW    = NB * G;
  localparam int RW    = AW + BW;

  logic [WA-1:0] a_abs;
  logic [WB-1:0] b_abs;
  logic [AW-1:0] am       [LAT];
  logic [BW-1:0] bm       [LAT];
  logic          sg       [LAT];
  logic [RW-1:0] acc      [LAT];
  logic [RW-1:0] acc_next [LAT];

  assign a_abs = a[WA-1] ? (~a + 1'b1) : a;
  assign b_abs = b[WB-1] ? (~b + 1'b1) : b;

  always_comb begin
    logic [2*G-1:0] pp;
    int             ia;
    int             ib;
    pp          = '0;
    acc_next[0] = '0;
    for (int k = 1; k < LAT; k++) begin
      ia = (k - 1) / NB;
      ib = (k - 1) % NB;
      if (k <= STEPS) begin
        pp = (2*G)'(am[k-1][ia*G +: G]) * (2*G)'(bm[k-1][ib*G +: G]);
        acc_next[k] = acc[k-1] + (RW'(pp) << ((ia + ib) * G));
      end else if (k == LAT - 1) begin
        acc_next[k] = sg[k-1] ? (~acc[k-1] + 1'b1) : acc[k-1];
      end else begin
        acc_next[k] = acc[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    am[0]  <= AW'(a_abs);
    bm[0]  <= BW'(b_abs);
    sg[0]  <= a[WA-1] ^ b[WB-1];
    acc[0] <= '0;
    for (int k = 1; k < LAT; k++) begin
      am[k]  <= am[k-1];
      bm[k]  <= bm[k-1];
      sg[k]  <= sg[k-1];
      acc[k] <= acc_next[k];
    end
  end

  assign p = acc[LAT-1][WA+WB-1:0];

endmodule
`default_nettype wire

### rtl/llcp_div.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero,
// saturating to QW signed bits. Depends on nothing.
`default_nettype none
module llcp_div #(
  parameter int NW  = 64,
  parameter int DNW = 32,
  parameter int QW  = 32
) (
  input  logic           clk,
  input  logic [NW-1:0]  num,
  input  logic [DNW-1:0] den,
  output logic [QW-1:0]  quo
);

  localparam int CW = (NW > DNW + QW) ? NW : DNW + QW;
  localparam int NS = QW + 2;

  logic [NW-1:0]  n_abs;
  logic [DNW-1:0] d_abs;
  logic [CW-1:0]  rem      [NS];
  logic [CW-1:0]  dv       [NS];
  logic [QW-1:0]  q        [NS];
  logic           sg       [NS];
  logic           ovf      [NS];
  logic [CW-1:0]  rem_next [NS];
  logic [QW-1:0]  q_next   [NS];
  logic [QW-1:0]  qf;
  logic [QW-1:0]  lim;

  assign n_abs = num[NW-1] ? (~num + 1'b1) : num;
  assign d_abs = den[DNW-1] ? (~den + 1'b1) : den;

  always_comb begin
    logic [CW-1:0] sh;
    sh          = '0;
    rem_next[0] = '0;
    q_next[0]   = '0;
    rem_next[1] = rem[0];
    q_next[1]   = q[0];
    for (int j = 0; j < QW; j++) begin
      sh            = dv[j+1] << (QW - 1 - j);
      rem_next[j+2] = rem[j+1];
      q_next[j+2]   = q[j+1];
      if (rem[j+1] >= sh) begin
        rem_next[j+2]          = rem[j+1] - sh;
        q_next[j+2][QW-1-j]    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= CW'(n_abs);
    dv[0]  <= CW'(d_abs);
    sg[0]  <= num[NW-1] ^ den[DNW-1];
    q[0]   <= '0;
    ovf[0] <= 1'b0;
    ovf[1] <= rem[0] >= (dv[0] << QW);
    for (int s = 1; s < NS; s++) begin
      rem[s] <= rem_next[s];
      q[s]   <= q_next[s];
      dv[s]  <= dv[s-1];
      sg[s]  <= sg[s-1];
    end
    for (int s = 2; s < NS; s++) begin
      ovf[s] <= ovf[s-1];
    end
  end

  assign qf  = q[NS-1];
  assign lim = {1'b1, {(QW-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (!sg[NS-1]) begin
      quo <= (ovf[NS-1] || qf[QW-1]) ? {1'b0, {(QW-1){1'b1}}} : qf;
    end else begin
      quo <= (ovf[NS-1] || (qf > lim)) ? lim : (~qf + 1'b1);
    end
  end

endmodule
`default_nettype wire

### rtl/line_line_closest_points_core.sv
// Top level: closest points between two 3D lines in fixed point, fully pipelined.
// Depends on llcp_pkg, llcp_delay, llcp_mul and llcp_div.
//
//  channel   signals                       direction  handshake
//  request   start, busy, request          in         taken when start && !busy
//  result    done, result                  out        one-cycle strobe on done
//
// One request enters per clock; busy stays low. Between the accepting edge and done
// a request passes the chunked multiplier chains (one 32x32 partial product per
// stage) and the divider, one quotient bit per stage. Synchronous reset clears
// all valid bits; the receiver cannot stall, so the pipeline never holds.
`default_nettype none
module line_line_closest_points_core #(
  parameter int FRAC_BITS = llcp_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  llcp_pkg::line_req_t request,
  output logic                done,
  output llcp_pkg::line_rsp_t result
);
  import llcp_pkg::*;

  localparam int W = COORD_W;

  assign busy = 1'b0;

  // stage 0: capture request
  logic      v0;
  line_req_t req0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    req0 <= request;
  end

  // stage 1: differences
  coord_t [2:0] a1_c;
  coord_t [2:0] a2_c;
  coord_t [2:0] b1_c;
  coord_t [2:0] b2_c;
  diff_t  [2:0] p13_c;
  diff_t  [2:0] p43_c;
  diff_t  [2:0] p21_c;

  assign a1_c = {req0.line_a_start_z, req0.line_a_start_y, req0.line_a_start_x};
  assign a2_c = {req0.line_a_end_z, req0.line_a_end_y, req0.line_a_end_x};
  assign b1_c = {req0.line_b_start_z, req0.line_b_start_y, req0.line_b_start_x};
  assign b2_c = {req0.line_b_end_z, req0.line_b_end_y, req0.line_b_end_x};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p13_c[k] = {a1_c[k][W-1], a1_c[k]} - {b1_c[k][W-1], b1_c[k]};
      p43_c[k] = {b2_c[k][W-1], b2_c[k]} - {b1_c[k][W-1], b1_c[k]};
      p21_c[k] = {a2_c[k][W-1], a2_c[k]} - {a1_c[k][W-1], a1_c[k]};
    end
  end

  logic         v1;
  side_a_t      sa1;
  diff_t [2:0]  p13_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    sa1.deg <= (p43_c == '0) || (p21_c == '0);
    sa1.a1  <= a1_c;
    sa1.b1  <= b1_c;
    sa1.p21 <= p21_c;
    sa1.p43 <= p43_c;
    p13_1   <= p13_c;
  end

  // phase A: dot products
  logic [2*PW-1:0] pr1343 [3];
  logic [2*PW-1:0] pr4321 [3];
  logic [2*PW-1:0] pr1321 [3];
  logic [2*PW-1:0] pr4343 [3];
  logic [2*PW-1:0] pr2121 [3];

  for (genvar k = 0; k < 3; k++) begin : g_dot
    llcp_mul #(.WA(PW), .WB(PW), .LAT(LAT_A)) u_m1343 (
      .clk(clk), .a(p13_1[k]), .b(sa1.p43[k]), .p(pr1343[k]));
    llcp_mul #(.WA(PW), .WB(PW), .LAT(LAT_A)) u_m4321 (
      .clk(clk), .a(sa1.p43[k]), .b(sa1.p21[k]), .p(pr4321[k]));
    llcp_mul #(.WA(PW), .WB(PW), .LAT(LAT_A)) u_m1321 (
      .clk(clk), .a(p13_1[k]), .b(sa1.p21[k]), .p(pr1321[k]));
    llcp_mul #(.WA(PW), .WB(PW), .LAT(LAT_A)) u_m4343 (
      .clk(clk), .a(sa1.p43[k]), .b(sa1.p43[k]), .p(pr4343[k]));
    llcp_mul #(.WA(PW), .WB(PW), .LAT(LAT_A)) u_m2121 (
      .clk(clk), .a(sa1.p21[k]), .b(sa1.p21[k]), .p(pr2121[k]));
  end

  logic    va;
  side_a_t sa_d;

  llcp_delay #(.T(side_a_t), .DEPTH(LAT_A)) u_dly_a (
    .clk(clk), .rst(rst), .in_vld(v1), .in_data(sa1), .out_vld(va), .out_data(sa_d));

  logic    v2;
  side_b_t sb2;
  dot_t    d1321_2;
  dot_t    d2121_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= va;
    end
    sb2.deg   <= sa_d.deg;
    sb2.a1    <= sa_d.a1;
    sb2.b1    <= sa_d.b1;
    sb2.p21   <= sa_d.p21;
    sb2.p43   <= sa_d.p43;
    sb2.d1343 <= DW'($signed(pr1343[0])) + DW'($signed(pr1343[1]))
               + DW'($signed(pr1343[2]));
    sb2.d4321 <= DW'($signed(pr4321[0])) + DW'($signed(pr4321[1]))
               + DW'($signed(pr4321[2]));
    sb2.d4343 <= DW'($signed(pr4343[0])) + DW'($signed(pr4343[1]))
               + DW'($signed(pr4343[2]));
    d1321_2   <= DW'($signed(pr1321[0])) + DW'($signed(pr1321[1]))
               + DW'($signed(pr1321[2]));
    d2121_2   <= DW'($signed(pr2121[0])) + DW'($signed(pr2121[1]))
               + DW'($signed(pr2121[2]));
  end

  // phase B: denom and numer
  logic [2*DW-1:0] pb_2121_4343;
  logic [2*DW-1:0] pb_4321_sq;
  logic [2*DW-1:0] pb_1343_4321;
  logic [2*DW-1:0] pb_1321_4343;

  llcp_mul #(.WA(DW), .WB(DW), .LAT(LAT_B)) u_mb0 (
    .clk(clk), .a(d2121_2), .b(sb2.d4343), .p(pb_2121_4343));
  llcp_mul #(.WA(DW), .WB(DW), .LAT(LAT_B)) u_mb1 (
    .clk(clk), .a(sb2.d4321), .b(sb2.d4321), .p(pb_4321_sq));
  llcp_mul #(.WA(DW), .WB(DW), .LAT(LAT_B)) u_mb2 (
    .clk(clk), .a(sb2.d1343), .b(sb2.d4321), .p(pb_1343_4321));
  llcp_mul #(.WA(DW), .WB(DW), .LAT(LAT_B)) u_mb3 (
    .clk(clk), .a(d1321_2), .b(sb2.d4343), .p(pb_1321_4343));

  logic    vb;
  side_b_t sb_d;

  llcp_delay #(.T(side_b_t), .DEPTH(LAT_B)) u_dly_b (
    .clk(clk), .rst(rst), .in_vld(v2), .in_data(sb2), .out_vld(vb), .out_data(sb_d));

  mid_t denom_c;
  mid_t numer_c;

  assign denom_c = MW'($signed(pb_2121_4343)) - MW'($signed(pb_4321_sq));
  assign numer_c = MW'($signed(pb_1343_4321)) - MW'($signed(pb_1321_4343));

  logic         v3;
  side_c_t      sc3;
  dot_t         d1343_3;
  dot_t         d4321_3;
  dot_t         d4343_3;
  coord_t [2:0] a1_3;
  diff_t  [2:0] p21_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= vb;
    end
    sc3.ok    <= !sb_d.deg && (denom_c != '0);
    sc3.numer <= numer_c;
    sc3.denom <= denom_c;
    sc3.b1    <= sb_d.b1;
    sc3.p43   <= sb_d.p43;
    d1343_3   <= sb_d.d1343;
    d4321_3   <= sb_d.d4321;
    d4343_3   <= sb_d.d4343;
    a1_3      <= sb_d.a1;
    p21_3     <= sb_d.p21;
  end

  // phase C: db, nb and Pa numerators
  logic [DW+MW-1:0]  pc_db;
  logic [DW+MW-1:0]  pc_t1;
  logic [DW+MW-1:0]  pc_t2;
  logic [W+MW-1:0]   pc_u [3];
  logic [MW+PW-1:0]  pc_v [3];

  llcp_mul #(.WA(DW), .WB(MW), .LAT(LAT_C)) u_mc_db (
    .clk(clk), .a(d4343_3), .b(sc3.denom), .p(pc_db));
  llcp_mul #(.WA(DW), .WB(MW), .LAT(LAT_C)) u_mc_t1 (
    .clk(clk), .a(d1343_3), .b(sc3.denom), .p(pc_t1));
  llcp_mul #(.WA(DW), .WB(MW), .LAT(LAT_C)) u_mc_t2 (
    .clk(clk), .a(d4321_3), .b(sc3.numer), .p(pc_t2));

  for (genvar k = 0; k < 3; k++) begin : g_pa
    llcp_mul #(.WA(W), .WB(MW), .LAT(LAT_C)) u_mc_u (
      .clk(clk), .a(a1_3[k]), .b(sc3.denom), .p(pc_u[k]));
    llcp_mul #(.WA(MW), .WB(PW), .LAT(LAT_C)) u_mc_v (
      .clk(clk), .a(sc3.numer), .b(p21_3[k]), .p(pc_v[k]));
  end

  logic    vc;
  side_c_t sc_d;

  llcp_delay #(.T(side_c_t), .DEPTH(LAT_C)) u_dly_c (
    .clk(clk), .rst(rst), .in_vld(v3), .in_data(sc3), .out_vld(vc), .out_data(sc_d));

  logic         v4;
  side_d_t      sd4;
  coord_t [2:0] b1_4;
  diff_t  [2:0] p43_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= vc;
    end
    sd4.ok    <= sc_d.ok;
    sd4.numer <= sc_d.numer;
    sd4.denom <= sc_d.denom;
    sd4.db    <= pc_db;
    sd4.nb    <= NBW'($signed(pc_t1)) + NBW'($signed(pc_t2));
    for (int k = 0; k < 3; k++) begin
      sd4.pa[k] <= PAW'($signed(pc_u[k])) + PAW'($signed(pc_v[k]));
    end
    b1_4  <= sc_d.b1;
    p43_4 <= sc_d.p43;
  end

  // phase D: Pb numerators
  logic [W+DBW-1:0]  pd_x [3];
  logic [NBW+PW-1:0] pd_y [3];

  for (genvar k = 0; k < 3; k++) begin : g_pb
    llcp_mul #(.WA(W), .WB(DBW), .LAT(LAT_D)) u_md_x (
      .clk(clk), .a(b1_4[k]), .b(sd4.db), .p(pd_x[k]));
    llcp_mul #(.WA(NBW), .WB(PW), .LAT(LAT_D)) u_md_y (
      .clk(clk), .a(sd4.nb), .b(p43_4[k]), .p(pd_y[k]));
  end

  logic    vd;
  side_d_t sd_d;

  llcp_delay #(.T(side_d_t), .DEPTH(LAT_D)) u_dly_d (
    .clk(clk), .rst(rst), .in_vld(v4), .in_data(sd4), .out_vld(vd), .out_data(sd_d));

  logic    v5;
  side_e_t se5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= vd;
    end
    se5.ok    <= sd_d.ok;
    se5.numer <= sd_d.numer;
    se5.denom <= sd_d.denom;
    se5.db    <= sd_d.db;
    se5.nb    <= sd_d.nb;
    se5.pa    <= sd_d.pa;
    for (int k = 0; k < 3; k++) begin
      se5.pb[k] <= PBW'($signed(pd_x[k])) + PBW'($signed(pd_y[k]));
    end
  end

  // phase E: divisions
  logic [W-1:0] q_mua;
  logic [W-1:0] q_mub;
  logic [W-1:0] q_pa [3];
  logic [W-1:0] q_pb [3];

  llcp_div #(.NW(MW + FRAC_BITS), .DNW(MW), .QW(W)) u_div_mua (
    .clk(clk), .num({se5.numer, {FRAC_BITS{1'b0}}}), .den(se5.denom), .quo(q_mua));
  llcp_div #(.NW(NBW + FRAC_BITS), .DNW(DBW), .QW(W)) u_div_mub (
    .clk(clk), .num({se5.nb, {FRAC_BITS{1'b0}}}), .den(se5.db), .quo(q_mub));

  for (genvar k = 0; k < 3; k++) begin : g_div
    llcp_div #(.NW(PAW), .DNW(MW), .QW(W)) u_div_pa (
      .clk(clk), .num(se5.pa[k]), .den(se5.denom), .quo(q_pa[k]));
    llcp_div #(.NW(PBW), .DNW(DBW), .QW(W)) u_div_pb (
      .clk(clk), .num(se5.pb[k]), .den(se5.db), .quo(q_pb[k]));
  end

  logic ve;
  logic oke;

  llcp_delay #(.T(logic), .DEPTH(LAT_Q)) u_dly_e (
    .clk(clk), .rst(rst), .in_vld(v5), .in_data(se5.ok), .out_vld(ve), .out_data(oke));

  // output register; invalid requests report all zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ve;
    end
    result.valid_res <= oke;
    result.param_a   <= oke ? q_mua   : '0;
    result.param_b   <= oke ? q_mub   : '0;
    result.near_a_x  <= oke ? q_pa[0] : '0;
    result.near_a_y  <= oke ? q_pa[1] : '0;
    result.near_a_z  <= oke ? q_pa[2] : '0;
    result.near_b_x  <= oke ? q_pb[0] : '0;
    result.near_b_y  <= oke ? q_pb[1] : '0;
    result.near_b_z  <= oke ? q_pb[2] : '0;
  end

endmodule
`default_nettype wire

### rtl/llcp_checker.sv
// Port-level checker for the closest-points core, bound to the top level.
// Depends on llcp_pkg.
`default_nettype none
module llcp_checker (
  input logic                clk,
  input logic                rst,
  input logic                busy,
  input logic                done,
  input llcp_pkg::line_rsp_t result
);
  import llcp_pkg::*;

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy asserted");

  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.valid_res) |->
      (result.param_a == '0) && (result.param_b == '0) &&
      (result.near_a_x == '0) && (result.near_a_y == '0) && (result.near_a_z == '0) &&
      (result.near_b_x == '0) && (result.near_b_y == '0) && (result.near_b_z == '0))
    else $error("degenerate result carries nonzero fields");

endmodule

bind line_line_closest_points_core llcp_checker u_llcp_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .result(result));
`default_nettype wire

### tb/line_line_closest_points_core_tb.sv
// Testbench for line_line_closest_points_core: a directed table, then random line pairs,
// each result checked against a wide-integer predictor. Depends on llcp_pkg and the core.
`timescale 1ns / 100ps
`default_nettype none
module line_line_closest_points_core_tb;
  import llcp_pkg::*;

  typedef logic signed [511:0] wide_t;
  typedef struct {
    line_req_t req;
    bit        typed;
    line_rsp_t rsp;
  } row_t;

  localparam int N_RANDOM = 600;
  localparam coord_t CMAX = 32'sh7fffffff;
  localparam coord_t CMIN = 32'sh80000000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  line_req_t request = '0;
  logic      done;
  line_rsp_t result;

  line_rsp_t closest_q[$];
  int        n_err = 0;
  row_t      rows[$];

  line_line_closest_points_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  always #2 clk = ~clk;

  function automatic coord_t sat_coord(wide_t v);
    if (v > wide_t'(CMAX)) return CMAX;
    if (v < wide_t'(CMIN)) return CMIN;
    return coord_t'(v[31:0]);
  endfunction

  function automatic wide_t dot3(wide_t u[3], wide_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic line_rsp_t closest_points(line_req_t r);
    wide_t a1[3], a2[3], b1[3], b2[3], p13[3], p43[3], p21[3];
    wide_t d1343, d4321, d1321, d4343, d2121, denom, numer, db, nb, pa, pb;
    coord_t pa_c[3], pb_c[3];
    line_rsp_t o;
    o = '0;
    a1[0] = r.line_a_start_x; a1[1] = r.line_a_start_y; a1[2] = r.line_a_start_z;
    a2[0] = r.line_a_end_x;   a2[1] = r.line_a_end_y;   a2[2] = r.line_a_end_z;
    b1[0] = r.line_b_start_x; b1[1] = r.line_b_start_y; b1[2] = r.line_b_start_z;
    b2[0] = r.line_b_end_x;   b2[1] = r.line_b_end_y;   b2[2] = r.line_b_end_z;
    for (int k = 0; k < 3; k++) begin
      p13[k] = a1[k] - b1[k];
      p43[k] = b2[k] - b1[k];
      p21[k] = a2[k] - a1[k];
    end
    if (p43[0] == 0 && p43[1] == 0 && p43[2] == 0) return o;
    if (p21[0] == 0 && p21[1] == 0 && p21[2] == 0) return o;
    d1343 = dot3(p13, p43);
    d4321 = dot3(p43, p21);
    d1321 = dot3(p13, p21);
    d4343 = dot3(p43, p43);
    d2121 = dot3(p21, p21);
    denom = d2121 * d4343 - d4321 * d4321;
    if (denom == 0) return o;
    numer = d1343 * d4321 - d1321 * d4343;
    db = d4343 * denom;
    nb = d1343 * denom + d4321 * numer;
    o.valid_res = 1'b1;
    o.param_a = sat_coord((numer * 65536) / denom);
    o.param_b = sat_coord((nb * 65536) / db);
    for (int k = 0; k < 3; k++) begin
      pa = a1[k] * denom + numer * p21[k];
      pb = b1[k] * db + nb * p43[k];
      pa_c[k] = sat_coord(pa / denom);
      pb_c[k] = sat_coord(pb / db);
    end
    o.near_a_x = pa_c[0]; o.near_a_y = pa_c[1]; o.near_a_z = pa_c[2];
    o.near_b_x = pb_c[0]; o.near_b_y = pb_c[1]; o.near_b_z = pb_c[2];
    return o;
  endfunction

  function automatic line_req_t mk_req(coord_t ax, coord_t ay, coord_t az,
                                       coord_t ex, coord_t ey, coord_t ez,
                                       coord_t bx, coord_t by, coord_t bz,
                                       coord_t fx, coord_t fy, coord_t fz);
    line_req_t r;
    r.line_a_start_x = ax; r.line_a_start_y = ay; r.line_a_start_z = az;
    r.line_a_end_x = ex;   r.line_a_end_y = ey;   r.line_a_end_z = ez;
    r.line_b_start_x = bx; r.line_b_start_y = by; r.line_b_start_z = bz;
    r.line_b_end_x = fx;   r.line_b_end_y = fy;   r.line_b_end_z = fz;
    return r;
  endfunction

  function automatic coord_t rand_coord(int mode);
    int pick;
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
      default: begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: return CMAX;
          1: return CMIN;
          2: return '0;
          3: return -32'sd1;
          4: return 32'sd65536;
          default: return coord_t'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic line_req_t rand_req();
    line_req_t r;
    coord_t c[12];
    int kind, mode, k;
    kind = $urandom_range(0, 9);
    mode = $urandom_range(0, 2);
    for (int i = 0; i < 12; i++)
      c[i] = rand_coord((kind < 3) ? $urandom_range(0, 2) : mode);
    if (kind == 7) begin
      for (int i = 0; i < 3; i++) c[3 + i] = c[i];
    end else if (kind == 8) begin
      for (int i = 0; i < 3; i++) c[9 + i] = c[6 + i];
    end else if (kind == 9) begin
      k = $urandom_range(1, 3);
      for (int i = 0; i < 12; i++) c[i] = rand_coord(1);
      for (int i = 0; i < 3; i++) c[9 + i] = c[6 + i] + k * (c[3 + i] - c[i]);
    end
    r = mk_req(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (a !== e) begin
      n_err++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    line_rsp_t e;
    if (!rst && start && !busy) closest_q.push_back(closest_points(request));
    if (!rst && done) begin
      if (closest_q.size() == 0) begin
        n_err++;
        $display("%0t unexpected result: expected none actual %h", $time, result);
      end else begin
        e = closest_q.pop_front();
        check_field("valid_res", 32'(e.valid_res), 32'(result.valid_res));
        check_field("param_a", e.param_a, result.param_a);
        check_field("param_b", e.param_b, result.param_b);
        check_field("near_a_x", e.near_a_x, result.near_a_x);
        check_field("near_a_y", e.near_a_y, result.near_a_y);
        check_field("near_a_z", e.near_a_z, result.near_a_z);
        check_field("near_b_x", e.near_b_x, result.near_b_x);
        check_field("near_b_y", e.near_b_y, result.near_b_y);
        check_field("near_b_z", e.near_b_z, result.near_b_z);
      end
    end
  end

  // typed rows: check the predictor agrees before use
  task automatic add_row(line_req_t r, bit typed, line_rsp_t rsp);
    row_t w;
    w.req = r; w.typed = typed; w.rsp = rsp;
    if (typed && closest_points(r) !== rsp) begin
      n_err++;
      $display("%0t table row mismatch: expected %h actual %h", $time, rsp, closest_points(r));
    end
    rows.push_back(w);
  endtask

  task automatic send_req(line_req_t r);
    start <= 1'b1;
    request <= r;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic idle_gap();
    int gap;
    gap = $urandom_range(1, 8);
    start <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  initial begin
    line_rsp_t zero_rsp, unit_rsp;
    int burst;
    zero_rsp = '0;
    unit_rsp = '0;
    unit_rsp.valid_res = 1'b1;
    unit_rsp.near_b_z = 32'sd65536;
    // zero-length A, zero-length B, both, parallel
    add_row(mk_req(1, 2, 3, 1, 2, 3, 0, 0, 0, 5, 6, 7), 1, zero_rsp);
    add_row(mk_req(0, 0, 0, 5, 6, 7, 9, 9, 9, 9, 9, 9), 1, zero_rsp);
    add_row(mk_req(CMAX, CMIN, 0, CMAX, CMIN, 0, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1, zero_rsp);
    add_row(mk_req(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 131072, 65536, 0), 1, zero_rsp);
    add_row(mk_req(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0, 1, 1, 1), 1, zero_rsp);
    // x axis against a line along y through (0,0,1): meet at origin and z=1
    add_row(mk_req(0, 0, 0, 65536, 0, 0, 0, 0, 65536, 0, 65536, 65536), 1, unit_rsp);
    add_row(mk_req(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX),
            0, zero_rsp);
    add_row(mk_req(CMIN, 0, 0, CMAX, 0, 0, 0, CMIN, 0, 0, CMAX, 1), 0, zero_rsp);
    add_row(mk_req(0, 0, 0, 1, 0, 0, CMAX, CMAX, CMAX, CMAX, CMAX - 1, CMAX), 0, zero_rsp);
    add_row(mk_req(0, 0, 0, 1, 1, 0, 0, 0, 1, CMIN, CMAX, 1), 0, zero_rsp);
    add_row(mk_req(-1, -1, -1, 0, 0, 0, 1, 0, 0, 1, 1, 0), 0, zero_rsp);
    add_row(mk_req(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 32'shf0f0f0f0,
                   32'sh33333333, 32'shcccccccc, 32'sh12345678, 32'sh87654321,
                   32'sh7f00ff00, 32'sh00ff00ff, 32'sh80ff0080, 32'sh01010101), 0, zero_rsp);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_req(rows[i].req);
    idle_gap();
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) send_req(rand_req());
      if (n >= N_RANDOM / 2 && n < N_RANDOM / 2 + burst) begin
        start <= 1'b0;
        wait (closest_q.size() == 0);
        @(posedge clk);
      end else begin
        idle_gap();
      end
    end
    start <= 1'b0;
    wait (closest_q.size() == 0);
    repeat (200) @(posedge clk);
    if (n_err == 0) begin
      $display("line_line_closest_points_core_tb: done, clean");
    end else begin
      $display("line_line_closest_points_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("line_line_closest_points_core_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
